// File: rtl/dlq_pkg.sv
`default_nettype none

package dlq_pkg;

    localparam int COUNT = 64;
    localparam int ID_W  = 8;
    localparam int IDX_W = (COUNT > 1) ? $clog2(COUNT) : 1;

    localparam logic [ID_W-1:0] NONE_ID  = '1;
    localparam logic [ID_W-1:0] COUNT_ID = ID_W'(COUNT);
    localparam logic [ID_W-1:0] LAST_ID  = ID_W'(COUNT - 1);

    typedef enum logic [0:0] {
        ACT_MARK = 1'b0,
        ACT_POP  = 1'b1
    } action_t;

    typedef enum logic [0:0] {
        ST_IDLE   = 1'b0,
        ST_LOOKUP = 1'b1
    } state_t;

    // link held by an entry that was never written since reset
    function automatic logic [ID_W-1:0] reset_link(input logic [IDX_W-1:0] idx);
        logic [ID_W-1:0] nxt;
        nxt = ID_W'(idx) + ID_W'(1);
        return (nxt < COUNT_ID) ? nxt : NONE_ID;
    endfunction

endpackage

`default_nettype wire

// File: rtl/dedup_linked_id_queue_top.sv
// an accepted input transaction moves to ST_LOOKUP, and the lookup's result is registered onto m_valid
// s_ready is low in ST_LOOKUP, so no new transaction is taken until the link table's read then write-back ends
// each request makes exactly one result; a result waiting on m_ready holds s_ready low
// reset (aresetn low, synchronous): ids 0 to COUNT-1 queued in ascending order,
// held by per-entry valid bits so no clearing pass is needed
`default_nettype none

module dedup_linked_id_queue_top
    import dlq_pkg::*;
(
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic            s_action,
    input  wire logic [ID_W-1:0] s_item_id,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic                 m_popped_valid,
    output logic [ID_W-1:0]      m_popped_id,
    output logic                 m_already_queued
);

    // link table
    logic [ID_W-1:0]  link_mem [COUNT];
    logic [COUNT-1:0] link_vld_reg;
    logic [ID_W-1:0]  rd_data_reg;
    logic             rd_vld_reg;

    state_t state_reg, state_next;

    logic            in_fire;
    logic            lookup;
    logic [ID_W-1:0] head_reg, head_next;
    logic [ID_W-1:0] tail_reg, tail_next;
    action_t         act_reg;
    logic [ID_W-1:0] id_reg;
    logic [IDX_W-1:0] addr_reg;
    logic [IDX_W-1:0] rd_addr;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ID_W-1:0]  wr_data;

    logic [ID_W-1:0] link;
    logic            res_popped_valid;
    logic [ID_W-1:0] res_popped_id;
    logic            res_already;

    logic            m_valid_reg;
    logic            m_popped_valid_reg;
    logic [ID_W-1:0] m_popped_id_reg;
    logic            m_already_reg;

    assign in_fire = s_valid && s_ready;
    assign rd_addr = (action_t'(s_action) == ACT_POP) ? head_reg[IDX_W-1:0]
                                                     : s_item_id[IDX_W-1:0];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready = 1'b0;
        lookup  = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_ready = !m_valid_reg || m_ready;
            ST_LOOKUP: lookup  = 1'b1;
            default: begin
                s_ready = 1'b0;
                lookup  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            act_reg  <= action_t'(s_action);
            id_reg   <= s_item_id;
            addr_reg <= rd_addr;
        end
    end

    // memory: synchronous read at accept, write-back during lookup
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            link_mem[wr_addr] <= wr_data;
        end
        if (in_fire) begin
            rd_data_reg <= link_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_vld_reg <= '0;
            rd_vld_reg   <= 1'b0;
        end else begin
            if (wr_en) begin
                link_vld_reg[wr_addr] <= 1'b1;
            end
            if (in_fire) begin
                rd_vld_reg <= link_vld_reg[rd_addr];
            end
        end
    end

    // entries never written read as their reset link
    assign link = rd_vld_reg ? rd_data_reg : reset_link(addr_reg);

    always_comb begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        wr_en            = 1'b0;
        wr_addr          = tail_reg[IDX_W-1:0];
        wr_data          = id_reg;
        res_popped_valid = 1'b0;
        res_popped_id    = '0;
        res_already      = 1'b0;
        if (lookup) begin
            unique case (act_reg)
                ACT_MARK: begin
                    priority if (id_reg >= COUNT_ID || tail_reg == id_reg
                                 || link != NONE_ID) begin
                        res_already = 1'b1;
                    end else if (tail_reg < COUNT_ID) begin
                        wr_en     = 1'b1;
                        tail_next = id_reg;
                    end else begin
                        head_next = id_reg;
                        tail_next = id_reg;
                    end
                end
                ACT_POP: begin
                    if (head_reg < COUNT_ID) begin
                        res_popped_valid = 1'b1;
                        res_popped_id    = head_reg;
                        wr_en            = 1'b1;
                        wr_addr          = head_reg[IDX_W-1:0];
                        wr_data          = NONE_ID;
                        if (link < COUNT_ID) begin
                            head_next = link;
                        end else begin
                            head_next = NONE_ID;
                            tail_next = NONE_ID;
                        end
                    end
                end
                default: res_already = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= LAST_ID;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (lookup) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (lookup) begin
            m_popped_valid_reg <= res_popped_valid;
            m_popped_id_reg    <= res_popped_id;
            m_already_reg      <= res_already;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_popped_valid   = m_popped_valid_reg;
    assign m_popped_id      = m_popped_id_reg;
    assign m_already_queued = m_already_reg;

    a_fire_to_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> state_reg == ST_LOOKUP)
        else $error("accepted transaction did not start a lookup");

    a_lookup_result: assert property (@(posedge aclk) disable iff (!aresetn)
        lookup |=> m_valid)
        else $error("lookup did not present a result");

    a_empty_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg == NONE_ID) == (tail_reg == NONE_ID))
        else $error("head and tail disagree on empty queue");

    a_head_range: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg == NONE_ID || head_reg < COUNT_ID)
        else $error("head holds an out of range id");

    a_write_in_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> lookup && !in_fire)
        else $error("link table written outside lookup");

    a_result_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_popped_valid && m_already_queued))
        else $error("pop and mark flags both set");

endmodule

`default_nettype wire

// File: verif/tb_dedup_linked_id_queue_top.sv
`timescale 1ns / 100ps

module tb_dedup_linked_id_queue_top;
    import dlq_pkg::*;

    localparam int TARGET_ITEMS = 1200;
    localparam int PHASE_LEN    = 150;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        action_t         act;
        logic [ID_W-1:0] id;
    } request_t;

    typedef struct packed {
        logic            popped_valid;
        logic [ID_W-1:0] popped_id;
        logic            already_queued;
    } answer_t;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    logic            s_action = ACT_MARK;
    logic [ID_W-1:0] s_item_id = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    logic            m_popped_valid;
    logic [ID_W-1:0] m_popped_id;
    logic            m_already_queued;

    dedup_linked_id_queue_top DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_item_id        (s_item_id),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_popped_valid   (m_popped_valid),
        .m_popped_id      (m_popped_id),
        .m_already_queued (m_already_queued)
    );

    always #6 aclk = ~aclk;

    // shadow copy of the linked list
    logic [ID_W-1:0] link_tab [0:COUNT-1];
    logic [ID_W-1:0] head_q;
    logic [ID_W-1:0] tail_q;

    request_t request_backlog[$];
    answer_t  pending_answers[$];
    request_t next_req;
    answer_t  want;

    int n_accepted   = 0;
    int n_results    = 0;
    int error_count  = 0;
    int cycle_cnt    = 0;
    int mark_appends = 0;
    int mark_dups    = 0;
    int pops_taken   = 0;
    int pops_empty   = 0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t result %0d: %s", $time, n_results, msg);
        error_count++;
    endtask

    function automatic answer_t apply_request(input action_t act, input logic [ID_W-1:0] id);
        answer_t         ans;
        logic [ID_W-1:0] nxt;
        ans = '0;
        if (act == ACT_MARK) begin
            if (id >= COUNT_ID || tail_q == id || link_tab[id] != NONE_ID) begin
                ans.already_queued = 1'b1;
                mark_dups++;
            end else begin
                if (tail_q < COUNT_ID) begin
                    link_tab[tail_q] = id;
                end else begin
                    head_q = id;
                end
                tail_q = id;
                mark_appends++;
            end
        end else if (head_q < COUNT_ID) begin
            ans.popped_valid = 1'b1;
            ans.popped_id    = head_q;
            nxt              = link_tab[head_q];
            link_tab[head_q] = NONE_ID;
            head_q           = nxt;
            if (nxt >= COUNT_ID) begin
                head_q = NONE_ID;
                tail_q = NONE_ID;
            end
            pops_taken++;
        end else begin
            pops_empty++;
        end
        return ans;
    endfunction

    // idle phases: none, sender idle, receiver stall, both
    function automatic int sender_idle_pct();
        case ((n_accepted / PHASE_LEN) % 4)
            1: return 71;
            3: return 27;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case ((n_accepted / PHASE_LEN) % 4)
            2: return 71;
            3: return 27;
            default: return 0;
        endcase
    endfunction

    function automatic void add_request(input action_t act, input logic [ID_W-1:0] id);
        request_t r;
        r.act = act;
        r.id  = id;
        request_backlog.push_back(r);
    endfunction

    function automatic logic [ID_W-1:0] live_id();
        // half the time from a small hot set so duplicates are common
        if ($urandom_range(1) == 0) begin
            return ID_W'($urandom_range(7));
        end
        return ID_W'($urandom_range(COUNT - 1));
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                pending_answers.push_back(apply_request(action_t'(s_action), s_item_id));
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (request_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
                    next_req = request_backlog.pop_front();
                    s_valid   <= 1'b1;
                    s_action  <= next_req.act;
                    s_item_id <= next_req.id;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_answers.size() == 0) begin
                    report_mismatch($sformatf("unexpected transaction pv=%0d id=%0d aq=%0d",
                                              m_popped_valid, m_popped_id, m_already_queued));
                end else begin
                    want = pending_answers.pop_front();
                    if (m_popped_valid !== want.popped_valid)
                        report_mismatch($sformatf("popped_valid got %0d want %0d",
                                                  m_popped_valid, want.popped_valid));
                    if (m_popped_id !== want.popped_id)
                        report_mismatch($sformatf("popped_id got %0d want %0d",
                                                  m_popped_id, want.popped_id));
                    if (m_already_queued !== want.already_queued)
                        report_mismatch($sformatf("already_queued got %0d want %0d",
                                                  m_already_queued, want.already_queued));
                end
                n_results++;
            end
            m_ready <= ($urandom_range(99) >= receiver_stall_pct());
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_answers.size());
            $display("tb_dedup_linked_id_queue_top failed");
            $finish;
        end
    end

    initial begin
        int kind;
        int len;
        int pop_pct;
        int base;

        for (int i = 0; i < COUNT; i++) begin
            link_tab[i] = (i + 1 < COUNT) ? ID_W'(i + 1) : NONE_ID;
        end
        head_q = '0;
        tail_q = LAST_ID;

        // directed: queue starts full with 0..COUNT-1
        add_request(ACT_MARK, 8'd0);        // head, already queued
        add_request(ACT_MARK, LAST_ID);     // tail, already queued
        add_request(ACT_MARK, 8'd17);       // middle, already queued
        add_request(ACT_MARK, COUNT_ID);    // first out-of-range id
        add_request(ACT_MARK, 8'd255);      // same code as the no-link marker
        add_request(ACT_MARK, 8'd170);
        add_request(ACT_POP,  8'd0);
        add_request(ACT_POP,  8'd255);      // id field ignored on pop
        add_request(ACT_MARK, 8'd0);        // re-append popped id
        add_request(ACT_MARK, 8'd0);        // now the tail
        add_request(ACT_MARK, 8'd1);        // popped, append after 0
        add_request(ACT_POP,  8'h55);
        add_request(ACT_MARK, 8'd2);        // popped just now
        add_request(ACT_MARK, 8'd3);        // current head
        add_request(ACT_POP,  8'hAA);
        add_request(ACT_MARK, LAST_ID);     // no longer tail but still linked

        // random segments of well-formed traffic, drains, fills and noise
        while (request_backlog.size() < TARGET_ITEMS) begin
            kind = $urandom_range(9);
            len  = $urandom_range(10, 60);
            if (kind <= 3) begin
                pop_pct = $urandom_range(10, 90);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(99) < pop_pct)
                        add_request(ACT_POP, ID_W'($urandom_range(255)));
                    else
                        add_request(ACT_MARK, live_id());
                end
            end else if (kind <= 5) begin
                // long pop run that can empty the queue and pop past the end
                len = $urandom_range(50, 75);
                for (int i = 0; i < len; i++) begin
                    add_request(ACT_POP, ID_W'($urandom_range(255)));
                end
            end else if (kind <= 7) begin
                base = $urandom_range(COUNT - 1);
                for (int i = 0; i < len; i++) begin
                    if (kind == 6)
                        add_request(ACT_MARK, ID_W'((base + i) % COUNT));
                    else
                        add_request(ACT_MARK, live_id());
                end
            end else begin
                for (int i = 0; i < len; i++) begin
                    add_request(action_t'($urandom_range(1)), ID_W'($urandom_range(255)));
                end
            end
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (request_backlog.size() != 0 || s_valid || pending_answers.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d requests, %0d results: %0d appends, %0d duplicate/out-of-range marks",
                 n_accepted, n_results, mark_appends, mark_dups);
        $display("%0d pops returned an id, %0d pops on an empty queue", pops_taken, pops_empty);
        if (error_count == 0) begin
            $display("tb_dedup_linked_id_queue_top passed");
        end else begin
            $display("tb_dedup_linked_id_queue_top failed");
        end
        $finish;
    end

endmodule
